### sv/tsrs_pkg.sv
// ----------------------------------------------------------------------------
// tsrs_pkg : shared types and constants for the time sync retry supervisor
// Mode codes, register indexes, timing constants and the config bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsrs_pkg;

    localparam int MAX_SHIFT_DEF = 10;

    localparam int NOW_W      = 32;
    localparam int FAIL_W     = 4;
    localparam int DELAY_W    = 20;
    localparam int TIMEOUT_W  = 10;
    localparam int INTERVAL_W = 17;
    localparam int TMO_MS_W   = 20;   // 600 s in ms fits
    localparam int INT_MS_W   = 27;   // 86400 s in ms fits

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = INTERVAL_W;

    localparam logic [FAIL_W-1:0]     FAIL_MAX         = '1;
    localparam logic [DELAY_W-1:0]    BASE_DELAY_MS    = DELAY_W'(1000);
    localparam logic [NOW_W-1:0]      REPORT_PERIOD_MS = NOW_W'(5000);
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_MIN_S    = TIMEOUT_W'(5);
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_MAX_S    = TIMEOUT_W'(600);
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST_S    = TIMEOUT_W'(30);
    localparam logic [INTERVAL_W-1:0] INTERVAL_MIN_S   = INTERVAL_W'(60);
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX_S   = INTERVAL_W'(86400);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST_S   = INTERVAL_W'(3600);
    localparam int                    MS_PER_S         = 1000;

    typedef enum logic [2:0] {
        MODE_DISABLED = 3'd0,
        MODE_UNSYNCED = 3'd1,
        MODE_SYNCING  = 3'd2,
        MODE_SYNCED   = 3'd3,
        MODE_FAILED   = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED        = 8'd0,
        REG_SERVER_PRESENT = 8'd1,
        REG_ATTEMPT_TMO    = 8'd2,
        REG_RESYNC_INT     = 8'd3
    } t_reg_idx;

    // configuration as seen by the datapath, times already in ms
    typedef struct packed {
        logic                enabled;
        logic                server_present;
        logic [TMO_MS_W-1:0] timeout_ms;
        logic [INT_MS_W-1:0] interval_ms;
    } t_cfg;

endpackage

`default_nettype wire

### sv/tsrs_if.sv
// ----------------------------------------------------------------------------
// tsrs_if : valid/ready channels of the time sync retry supervisor
// Poll input, result output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tsrs_poll_if;
    logic                         valid;
    logic                         ready;
    logic [tsrs_pkg::NOW_W-1:0]   now_ms;
    logic                         link_up;
    logic                         sync_complete;

    modport source (output valid, now_ms, link_up, sync_complete, input ready);
    modport sink   (input valid, now_ms, link_up, sync_complete, output ready);
endinterface

interface tsrs_res_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   mode;
    logic                         start_request;
    logic                         stop_request;
    logic                         status_report;
    logic [tsrs_pkg::DELAY_W-1:0] retry_delay_ms;

    modport source (output valid, mode, start_request, stop_request, status_report,
                    retry_delay_ms, input ready);
    modport sink   (input valid, mode, start_request, stop_request, status_report,
                    retry_delay_ms, output ready);
endinterface

interface tsrs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tsrs_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [tsrs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

### sv/time_sync_retry_supervisor_unit.sv
// ----------------------------------------------------------------------------
// time_sync_retry_supervisor_unit : time sync supervisor with exponential backoff
// Path: poll beat -> poll register -> result register -> result beat.
// Throughput: one poll per cycle while the result sink does not stall; a poll sees all state left by the previous one.
// Reset: synchronous, active low; mode unsynced, timestamps and backoff cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Structure
//   poll beat  -> r_s1_* (poll register)
//   r_s1_*     -> step logic against the mode/timestamp state -> r_out_* (result)
// State and result register are loaded on the same edge, so the next poll in
// the poll register already sees the updated state. The result register is
// held while the sink stalls; the poll register only takes a new beat when
// it is empty or its contents move on, so nothing is dropped or repeated.
//
// Timing elapsed values are (now - stamp) mod 2^32, compared against limits
// held in ms by the config block (products by 1000 done at write time).

module time_sync_retry_supervisor_unit #(
    parameter int MAX_SHIFT = tsrs_pkg::MAX_SHIFT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tsrs_cfg_if.sink    i_cfg,
    tsrs_poll_if.sink   i_poll,
    tsrs_res_if.source  o_res
);

    localparam logic [tsrs_pkg::FAIL_W-1:0] SHIFT_CAP = tsrs_pkg::FAIL_W'(MAX_SHIFT);

    tsrs_pkg::t_cfg cfg;

    tsrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // ---------------- poll register ----------------
    logic                       r_s1_valid;
    logic [tsrs_pkg::NOW_W-1:0] r_s1_now;
    logic                       r_s1_link;
    logic                       r_s1_done;
    logic                       s1_adv;
    logic                       poll_take;

    // ---------------- supervisor state ----------------
    tsrs_pkg::t_mode                r_mode,    n_mode;
    logic [tsrs_pkg::NOW_W-1:0]     r_attempt, n_attempt;
    logic [tsrs_pkg::NOW_W-1:0]     r_last,    n_last;
    logic [tsrs_pkg::NOW_W-1:0]     r_entry,   n_entry;
    logic [tsrs_pkg::FAIL_W-1:0]    r_fail,    n_fail;
    logic [tsrs_pkg::DELAY_W-1:0]   r_backoff, n_backoff;

    // ---------------- result register ----------------
    logic                           r_out_valid;
    tsrs_pkg::t_mode                r_out_mode;
    logic                           r_out_start;
    logic                           r_out_stop;
    logic                           r_out_report;
    logic [tsrs_pkg::DELAY_W-1:0]   r_out_delay;

    // step results
    logic                           n_start;
    logic                           n_stop;
    logic                           n_report;

    // scratch for the step
    tsrs_pkg::t_mode                eff_mode;
    logic [tsrs_pkg::NOW_W-1:0]     since_attempt;
    logic [tsrs_pkg::NOW_W-1:0]     since_sync;
    logic [tsrs_pkg::NOW_W-1:0]     since_entry;
    logic [tsrs_pkg::FAIL_W-1:0]    fail_inc;
    logic [tsrs_pkg::FAIL_W-1:0]    shift;
    logic [tsrs_pkg::DELAY_W-1:0]   raw_delay;
    logic                           resync_due;

    // Handshake: result slot frees when empty or being taken; poll slot frees
    // when empty or moving into the result slot.
    assign s1_adv       = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_poll.ready = !r_s1_valid || s1_adv;
    assign poll_take    = i_poll.valid && i_poll.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_s1_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (poll_take) begin
            r_s1_now  <= i_poll.now_ms;
            r_s1_link <= i_poll.link_up;
            r_s1_done <= i_poll.sync_complete;
        end
    end

    // Elapsed times and backoff candidate
    assign since_attempt = r_s1_now - r_attempt;
    assign since_sync    = r_s1_now - r_last;
    assign since_entry   = r_s1_now - r_entry;
    assign fail_inc      = (r_fail == tsrs_pkg::FAIL_MAX) ? r_fail
                                                          : r_fail + tsrs_pkg::FAIL_W'(1);
    assign shift         = (fail_inc > SHIFT_CAP) ? SHIFT_CAP : fail_inc;
    assign raw_delay     = tsrs_pkg::BASE_DELAY_MS << shift;
    assign resync_due    = since_sync >= tsrs_pkg::NOW_W'(cfg.interval_ms);

    // Step logic: one poll against the current state
    always_comb begin
        n_mode    = r_mode;
        n_attempt = r_attempt;
        n_last    = r_last;
        n_entry   = r_entry;
        n_fail    = r_fail;
        n_backoff = r_backoff;
        n_start   = 1'b0;
        n_stop    = 1'b0;
        n_report  = 1'b0;
        eff_mode  = r_mode;

        if (!cfg.enabled) begin
            n_mode    = tsrs_pkg::MODE_DISABLED;
            n_fail    = '0;
            n_backoff = '0;
        end else begin
            // Coming out of disabled: fresh unsynced entry, then step as unsynced
            if (r_mode == tsrs_pkg::MODE_DISABLED) begin
                n_fail    = '0;
                n_backoff = '0;
                n_mode    = tsrs_pkg::MODE_UNSYNCED;
                n_entry   = r_s1_now;
                eff_mode  = tsrs_pkg::MODE_UNSYNCED;
            end

            if (!r_s1_link) begin
                // link lost: back to unsynced, attempt timer restarts
                if (eff_mode != tsrs_pkg::MODE_UNSYNCED) begin
                    n_entry = r_s1_now;
                end
                n_mode    = tsrs_pkg::MODE_UNSYNCED;
                n_attempt = r_s1_now;
            end else begin
                unique case (eff_mode)
                    tsrs_pkg::MODE_UNSYNCED: begin
                        n_entry = r_s1_now;
                        if (cfg.server_present) begin
                            n_mode    = tsrs_pkg::MODE_SYNCING;
                            n_attempt = r_s1_now;
                            n_start   = 1'b1;
                        end else begin
                            n_mode = tsrs_pkg::MODE_FAILED;
                        end
                    end
                    tsrs_pkg::MODE_FAILED: begin
                        if (since_attempt >= tsrs_pkg::NOW_W'(r_backoff)) begin
                            n_entry = r_s1_now;
                            if (cfg.server_present) begin
                                n_mode    = tsrs_pkg::MODE_SYNCING;
                                n_attempt = r_s1_now;
                                n_start   = 1'b1;
                            end else begin
                                n_mode = tsrs_pkg::MODE_FAILED;
                            end
                        end
                    end
                    tsrs_pkg::MODE_SYNCING: begin
                        if (r_s1_done) begin
                            n_last    = r_s1_now;
                            n_fail    = '0;
                            n_backoff = '0;
                            n_mode    = tsrs_pkg::MODE_SYNCED;
                            n_entry   = r_s1_now;
                        end else if (since_attempt >= tsrs_pkg::NOW_W'(cfg.timeout_ms)) begin
                            // timeout: double the delay, capped at the interval
                            n_fail = fail_inc;
                            if (tsrs_pkg::INT_MS_W'(raw_delay) > cfg.interval_ms) begin
                                n_backoff = cfg.interval_ms[tsrs_pkg::DELAY_W-1:0];
                            end else begin
                                n_backoff = raw_delay;
                            end
                            n_attempt = r_s1_now;
                            n_stop    = 1'b1;
                            n_mode    = tsrs_pkg::MODE_FAILED;
                            n_entry   = r_s1_now;
                        end
                    end
                    tsrs_pkg::MODE_SYNCED: begin
                        // a resync restamps the entry time, so no report with it
                        if (resync_due) begin
                            n_fail  = fail_inc;
                            n_entry = r_s1_now;
                            if (cfg.server_present) begin
                                n_mode    = tsrs_pkg::MODE_SYNCING;
                                n_attempt = r_s1_now;
                                n_start   = 1'b1;
                            end else begin
                                n_mode = tsrs_pkg::MODE_FAILED;
                            end
                        end else if (since_entry >= tsrs_pkg::REPORT_PERIOD_MS) begin
                            n_entry  = r_s1_now;
                            n_report = 1'b1;
                        end
                    end
                    default: begin
                        n_mode  = tsrs_pkg::MODE_UNSYNCED;
                        n_entry = r_s1_now;
                    end
                endcase
            end
        end
    end

    // State moves only when a poll moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tsrs_pkg::MODE_UNSYNCED;
            r_attempt <= '0;
            r_last    <= '0;
            r_entry   <= '0;
            r_fail    <= '0;
            r_backoff <= '0;
        end else if (s1_adv) begin
            r_mode    <= n_mode;
            r_attempt <= n_attempt;
            r_last    <= n_last;
            r_entry   <= n_entry;
            r_fail    <= n_fail;
            r_backoff <= n_backoff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_mode   <= n_mode;
            r_out_start  <= n_start;
            r_out_stop   <= n_stop;
            r_out_report <= n_report;
            r_out_delay  <= n_backoff;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.mode           = r_out_mode;
    assign o_res.start_request  = r_out_start;
    assign o_res.stop_request   = r_out_stop;
    assign o_res.status_report  = r_out_report;
    assign o_res.retry_delay_ms = r_out_delay;

endmodule

`default_nettype wire

### sv/tsrs_cfg.sv
// ----------------------------------------------------------------------------
// tsrs_cfg : configuration register file
// Clamps the written timeout and interval to range and holds them in ms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsrs_cfg (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tsrs_cfg_if.sink      i_cfg,
    output tsrs_pkg::t_cfg o_cfg
);

    tsrs_pkg::t_cfg                       r_cfg;
    tsrs_pkg::t_cfg                       n_cfg;
    logic [tsrs_pkg::TIMEOUT_W-1:0]       tmo_s;
    logic [tsrs_pkg::INTERVAL_W-1:0]      int_s;
    logic [tsrs_pkg::TIMEOUT_W-1:0]       tmo_clamped;
    logic [tsrs_pkg::INTERVAL_W-1:0]      int_clamped;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    assign tmo_s = i_cfg.data[tsrs_pkg::TIMEOUT_W-1:0];
    assign int_s = i_cfg.data[tsrs_pkg::INTERVAL_W-1:0];

    always_comb begin
        priority if (tmo_s < tsrs_pkg::TIMEOUT_MIN_S) begin
            tmo_clamped = tsrs_pkg::TIMEOUT_MIN_S;
        end else if (tmo_s > tsrs_pkg::TIMEOUT_MAX_S) begin
            tmo_clamped = tsrs_pkg::TIMEOUT_MAX_S;
        end else begin
            tmo_clamped = tmo_s;
        end
        priority if (int_s < tsrs_pkg::INTERVAL_MIN_S) begin
            int_clamped = tsrs_pkg::INTERVAL_MIN_S;
        end else if (int_s > tsrs_pkg::INTERVAL_MAX_S) begin
            int_clamped = tsrs_pkg::INTERVAL_MAX_S;
        end else begin
            int_clamped = int_s;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                tsrs_pkg::REG_ENABLED:        n_cfg.enabled        = i_cfg.data[0];
                tsrs_pkg::REG_SERVER_PRESENT: n_cfg.server_present = i_cfg.data[0];
                tsrs_pkg::REG_ATTEMPT_TMO: begin
                    n_cfg.timeout_ms = tsrs_pkg::TMO_MS_W'(tmo_clamped)
                                     * tsrs_pkg::TMO_MS_W'(tsrs_pkg::MS_PER_S);
                end
                tsrs_pkg::REG_RESYNC_INT: begin
                    n_cfg.interval_ms = tsrs_pkg::INT_MS_W'(int_clamped)
                                      * tsrs_pkg::INT_MS_W'(tsrs_pkg::MS_PER_S);
                end
                default: n_cfg = r_cfg;   // unmapped index: write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled        <= 1'b0;
            r_cfg.server_present <= 1'b1;
            r_cfg.timeout_ms     <= tsrs_pkg::TMO_MS_W'(tsrs_pkg::TIMEOUT_RST_S)
                                  * tsrs_pkg::TMO_MS_W'(tsrs_pkg::MS_PER_S);
            r_cfg.interval_ms    <= tsrs_pkg::INT_MS_W'(tsrs_pkg::INTERVAL_RST_S)
                                  * tsrs_pkg::INT_MS_W'(tsrs_pkg::MS_PER_S);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### sv/tsrs_checker.sv
// ----------------------------------------------------------------------------
// tsrs_checker : port-level checks on the supervisor result channel
// Bound to the top level; watches result beats only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsrs_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_valid,
    input wire                         i_ready,
    input wire [2:0]                   i_mode,
    input wire                         i_start,
    input wire                         i_stop,
    input wire                         i_report,
    input wire [tsrs_pkg::DELAY_W-1:0] i_delay
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_mode) && $stable(i_delay)
                                && $stable({i_start, i_stop, i_report}))
        else $error("result beat changed while stalled");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_start |-> i_mode == tsrs_pkg::MODE_SYNCING && !i_stop && !i_report)
        else $error("start pulse outside syncing");

    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_stop |-> i_mode == tsrs_pkg::MODE_FAILED && i_delay != '0)
        else $error("stop pulse without failed mode and backoff");

    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_report |-> i_mode == tsrs_pkg::MODE_SYNCED && i_delay == '0)
        else $error("status report outside synced");

    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_mode == tsrs_pkg::MODE_DISABLED |-> i_delay == '0)
        else $error("backoff not cleared while disabled");

endmodule

bind time_sync_retry_supervisor_unit tsrs_checker u_tsrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_mode   (o_res.mode),
    .i_start  (o_res.start_request),
    .i_stop   (o_res.stop_request),
    .i_report (o_res.status_report),
    .i_delay  (o_res.retry_delay_ms)
);

`default_nettype wire
